// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// Text console writer package: screen geometry, cell codes, controller states,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package tcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CODE_W      = 8;
  localparam int CELL_W      = 16;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CODE_W-1:0] CODE_NEWLINE      = 8'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE    = 8'd8;
  localparam logic [CODE_W-1:0] CODE_BLANK        = 8'h20;
  localparam logic [COL_W-1:0]  BACKSPACE_MIN_COL = 7'd6;
  localparam logic [CELL_W-1:0] CELL_RESET        = 16'h0720;
  localparam logic [CODE_W-1:0] TEXT_COLOR_RESET  = 8'h07;

  localparam logic KIND_PRINT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_COPY,
    S_DRAIN,
    S_FILL
  } tcw_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
    logic emit_read;
    logic copy;
    logic drain;
    logic fill;
    logic fill_reset;
  } tcw_cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic cnt_last;
  } tcw_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(col);
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [CODE_W-1:0] ch,
                                                 input logic [CODE_W-1:0] attr);
    make_cell = {attr, ch};
  endfunction

endpackage

// ----- rtl/text_console_writer_top.sv -----
`timescale 1ns / 1ps
// Text console writer top: 80x25 cell console, APB color register.
// Print: accepted on start & !busy, latched, then executed in S_EXEC; result strobe registered from S_EXEC.
// Read: executed in S_EXEC, cell captured in S_READ. A new item is taken only once busy falls.
// Scroll: a copy walk moves rows 1-24 up one row, then a bottom-row fill writes blanks;
// busy throughout, result strobed as the fill ends. Results last one cycle; the receiver cannot stall.
// Reset: synchronous, rst_n low; then a memory clear of every cell with busy high.
module text_console_writer_top import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [CODE_W-1:0]  in_char_code,
  input  logic [ROW_W-1:0]   in_read_row,
  input  logic [COL_W-1:0]   in_read_col,
  output logic               out_strobe,
  output logic [COL_W-1:0]   out_cursor_col,
  output logic [ROW_W-1:0]   out_cursor_row,
  output logic [CELL_W-1:0]  out_cell_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  tcw_cmd_t          cmd;
  tcw_sts_t          sts;
  logic [CODE_W-1:0] text_color_r;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TEXT_COLOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_color_r <= pwdata[CODE_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(text_color_r) : '0;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcw_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .text_color     (text_color_r),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_data  (out_cell_data)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on consecutive cycles");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_cursor_row < ROW_W'(SCREEN_ROWS)) &&
                   (out_cursor_col < COL_W'(SCREEN_COLS)))
    else $error("cursor outside screen");

  a_print_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(u_datapath.cmd.emit)) |-> (out_cell_data == '0))
    else $error("print result carries cell data");
`endif

endmodule

// ----- rtl/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// Text console writer controller: sequences reset clear, item execution,
// cell reads and the scroll copy/fill walk. Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd,
  output logic     busy
);

  tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_read)          state_nxt = S_READ;
        else if (sts.need_scroll) state_nxt = S_COPY;
        else                      state_nxt = S_IDLE;
      end
      S_READ:  state_nxt = S_IDLE;
      S_COPY: begin
        if (sts.cnt_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FILL;
      S_FILL: begin
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.fill       = 1'b1;
        cmd.fill_reset = 1'b1;
      end
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.emit = !sts.is_read && !sts.need_scroll;
      end
      S_READ:  cmd.emit_read = 1'b1;
      S_COPY:  cmd.copy = 1'b1;
      S_DRAIN: cmd.drain = 1'b1;
      S_FILL: begin
        cmd.fill = 1'b1;
        cmd.emit = sts.cnt_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/tcw_datapath.sv -----
`timescale 1ns / 1ps
// Text console writer datapath: screen memory, cursor, item latch, walk
// counter and result registers. Driven by tcw_ctrl; depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_cmd_t          cmd,
  input  logic              in_kind,
  input  logic [CODE_W-1:0] in_char_code,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic [CODE_W-1:0] text_color,
  output tcw_sts_t          sts,
  output logic              out_strobe,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [CELL_W-1:0] out_cell_data
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;

  logic              kind_r;
  logic [CODE_W-1:0] code_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W:0]   cnt_r, cnt_nxt;
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              strobe_r;
  logic [CELL_W-1:0] cell_data_r;

  logic              is_read;
  logic              rd_in_range;
  logic              pr_we;
  logic [COL_W-1:0]  pr_col;
  logic [CODE_W-1:0] pr_ch;
  logic [ROW_W-1:0]  row_adv;
  logic              need_scroll;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [ADDR_W-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      code_r <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
  end

  assign is_read     = (kind_r == KIND_READ);
  assign rd_in_range = (rrow_r < ROW_W'(SCREEN_ROWS)) && (rcol_r < COL_W'(SCREEN_COLS));

  // print step: cursor move and the single cell write it may cause
  always_comb begin
    pr_we   = 1'b0;
    pr_col  = col_r;
    pr_ch   = code_r;
    col_nxt = col_r;
    row_adv = row_r;
    case (code_r)
      CODE_NEWLINE: begin
        col_nxt = '0;
        row_adv = row_r + 1'b1;
      end
      CODE_BACKSPACE: begin
        if (col_r >= BACKSPACE_MIN_COL) begin
          col_nxt = col_r - 1'b1;
          pr_we   = 1'b1;
          pr_col  = col_r - 1'b1;
          pr_ch   = CODE_BLANK;
        end
      end
      default: begin
        pr_we = 1'b1;
        if (col_r == COL_W'(SCREEN_COLS - 1)) begin
          col_nxt = '0;
          row_adv = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    endcase
    need_scroll = (row_adv == ROW_W'(SCREEN_ROWS));
    row_nxt     = need_scroll ? ROW_W'(SCREEN_ROWS - 1) : row_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.exec && !is_read) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // walk counter: reset clear target, copy source, then fill target
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.exec)       cnt_nxt = (ADDR_W+1)'(SCREEN_COLS);
    else if (cmd.drain) cnt_nxt = (ADDR_W+1)'(CELL_COUNT - SCREEN_COLS);
    else if (cmd.copy || cmd.fill) cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      wr_pend_r <= cmd.copy;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= cnt_r[ADDR_W-1:0] - ADDR_W'(SCREEN_COLS);
  end

  // write port: pending copy transfer, fill, or the print write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cell_addr(row_r, pr_col);
    mem_wd = make_cell(pr_ch, text_color);
    if (wr_pend_r) begin
      mem_we = 1'b1;
      mem_wa = wr_addr_r;
      mem_wd = rdata_r;
    end else if (cmd.fill) begin
      mem_we = 1'b1;
      mem_wa = cnt_r[ADDR_W-1:0];
      mem_wd = cmd.fill_reset ? CELL_RESET : make_cell(CODE_BLANK, text_color);
    end else if (cmd.exec && !is_read) begin
      mem_we = pr_we;
    end
  end

  assign mem_ra = cmd.copy ? cnt_r[ADDR_W-1:0] : cell_addr(rrow_r, rcol_r);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit || cmd.emit_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_read) begin
      cell_data_r <= rd_in_range ? rdata_r : '0;
    end else if (cmd.emit) begin
      cell_data_r <= '0;
    end
  end

  assign sts.is_read     = is_read;
  assign sts.need_scroll = need_scroll;
  assign sts.cnt_last    = (cnt_r == (ADDR_W+1)'(CELL_COUNT - 1));

  assign out_strobe     = strobe_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_cell_data  = cell_data_r;

endmodule
